// ===== rtl/core/tci_pkg.sv =====
// Shared types, constants and scanner functions for the token classifier and indexer.
// Used by every module under rtl/core; depends on nothing else.
package tci_pkg;

	localparam int IndexBits = 10;
	localparam int CfgBits = 10;
	localparam int CfgIdxBits = 2;
	localparam logic [IndexBits-1:0] IndexMax = {IndexBits{1'b1}};

	localparam logic [CfgIdxBits-1:0] CfgIdBase = 2'd0;
	localparam logic [CfgIdxBits-1:0] CfgIntBase = 2'd1;
	localparam logic [CfgIdxBits-1:0] CfgDecBase = 2'd2;
	localparam logic [CfgIdxBits-1:0] CfgExpBase = 2'd3;

	localparam logic [CfgBits-1:0] IdBaseReset = 10'd0;
	localparam logic [CfgBits-1:0] IntBaseReset = 10'd201;
	localparam logic [CfgBits-1:0] DecBaseReset = 10'd301;
	localparam logic [CfgBits-1:0] ExpBaseReset = 10'd401;

	localparam logic [IndexBits-1:0] CodeNone = IndexBits'(0);
	localparam logic [IndexBits-1:0] CodeAnd = IndexBits'(501);
	localparam logic [IndexBits-1:0] CodeOr = IndexBits'(502);
	localparam logic [IndexBits-1:0] CodeGt = IndexBits'(503);
	localparam logic [IndexBits-1:0] CodeLt = IndexBits'(504);
	localparam logic [IndexBits-1:0] CodeGe = IndexBits'(505);
	localparam logic [IndexBits-1:0] CodeLe = IndexBits'(506);
	localparam logic [IndexBits-1:0] CodeNe = IndexBits'(507);
	localparam logic [IndexBits-1:0] CodeEq = IndexBits'(508);
	localparam logic [IndexBits-1:0] CodeMul = IndexBits'(510);
	localparam logic [IndexBits-1:0] CodeDiv = IndexBits'(511);
	localparam logic [IndexBits-1:0] CodeAdd = IndexBits'(512);
	localparam logic [IndexBits-1:0] CodeSub = IndexBits'(513);
	localparam logic [IndexBits-1:0] CodeComma = IndexBits'(515);
	localparam logic [IndexBits-1:0] CodeSemi = IndexBits'(516);
	localparam logic [IndexBits-1:0] CodeInt = IndexBits'(517);
	localparam logic [IndexBits-1:0] CodeFloat = IndexBits'(518);
	localparam logic [IndexBits-1:0] CodeAssign = IndexBits'(800);

	localparam logic [2:0] CountMax = 3'd7;

	typedef enum logic [4:0] {
		ST_START, ST_IDENT, ST_REL1, ST_REL2, ST_MUL, ST_AMP, ST_AMP2,
		ST_BAR, ST_BAR2, ST_SIGN, ST_INT, ST_DOT, ST_DEC, ST_E, ST_ESIGN,
		ST_EXP, ST_SEP, ST_DEAD
	} scan_state_t;

	typedef enum logic [3:0] {
		CLS_ERROR = 4'd0, CLS_ID = 4'd1, CLS_RESERVED = 4'd2, CLS_RELOP = 4'd3,
		CLS_ASSIGN = 4'd4, CLS_LOGIC = 4'd5, CLS_ARITH = 4'd6, CLS_INT = 4'd7,
		CLS_DEC = 4'd8, CLS_EXP = 4'd9, CLS_SEP = 4'd10
	} token_class_t;

	typedef enum logic [2:0] {
		CTR_NONE, CTR_ID, CTR_INT, CTR_DEC, CTR_EXP
	} ctr_sel_t;

	typedef struct packed {
		token_class_t cls;
		logic [IndexBits-1:0] code;
		ctr_sel_t ctr;
	} tci_rec_t;

	function automatic logic is_digit(input logic [7:0] c);
		return (c >= "0") && (c <= "9");
	endfunction

	function automatic logic is_alpha(input logic [7:0] c);
		return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
	endfunction

	function automatic logic [7:0] int_char(input logic [2:0] pos);
		logic [7:0] r;
		unique case (pos)
			3'd0: r = "i";
			3'd1: r = "n";
			default: r = "t";
		endcase
		return r;
	endfunction

	function automatic logic [7:0] float_char(input logic [2:0] pos);
		logic [7:0] r;
		unique case (pos)
			3'd0: r = "f";
			3'd1: r = "l";
			3'd2: r = "o";
			3'd3: r = "a";
			default: r = "t";
		endcase
		return r;
	endfunction

	function automatic scan_state_t next_state(input scan_state_t s, input logic [7:0] c);
		scan_state_t n;
		n = ST_DEAD;
		unique case (s)
			ST_START: begin
				if (is_alpha(c)) n = ST_IDENT;
				else if (c == "<" || c == ">" || c == "=" || c == "!") n = ST_REL1;
				else if (c == "*" || c == "/") n = ST_MUL;
				else if (c == "&") n = ST_AMP;
				else if (c == "|") n = ST_BAR;
				else if (c == "+" || c == "-") n = ST_SIGN;
				else if (is_digit(c)) n = ST_INT;
				else if (c == ";" || c == ",") n = ST_SEP;
			end
			ST_IDENT: if (is_alpha(c) || is_digit(c)) n = ST_IDENT;
			ST_REL1: if (c == "=") n = ST_REL2;
			ST_AMP: if (c == "&") n = ST_AMP2;
			ST_BAR: if (c == "|") n = ST_BAR2;
			ST_SIGN: if (is_digit(c)) n = ST_INT;
			ST_INT: begin
				if (is_digit(c)) n = ST_INT;
				else if (c == ".") n = ST_DOT;
				else if (c == "e" || c == "E") n = ST_E;
			end
			ST_DOT: if (is_digit(c)) n = ST_DEC;
			ST_DEC: begin
				if (is_digit(c)) n = ST_DEC;
				else if (c == "e" || c == "E") n = ST_E;
			end
			ST_E: begin
				if (c == "+" || c == "-") n = ST_ESIGN;
				else if (is_digit(c)) n = ST_EXP;
			end
			ST_ESIGN: if (is_digit(c)) n = ST_EXP;
			ST_EXP: if (is_digit(c)) n = ST_EXP;
			default: n = ST_DEAD;
		endcase
		return n;
	endfunction

endpackage

// ===== rtl/core/tci_front.sv =====
// Front end: accepts characters, runs the scanner automaton and classifies each token.
// On the last character it pushes one token record into the queue. Depends on tci_pkg.
module tci_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [7:0]          char_code,
	input  logic                is_last,
	input  logic                q_ready,
	output logic                q_valid,
	output tci_pkg::tci_rec_t   q_rec
);
	import tci_pkg::*;

	scan_state_t scan_q;
	logic [7:0] first_q;
	logic [2:0] count_q;
	logic [1:0] match_q;

	scan_state_t scan_nx;
	logic [7:0] first_nx;
	logic [2:0] count_nx;
	logic [1:0] match_nx;
	logic [1:0] prev_m;
	logic take;

	assign in_ready = q_ready;
	assign take = in_valid && in_ready;

	always_comb begin
		prev_m = (count_q == 3'd0) ? 2'b11 : match_q;
		first_nx = (count_q == 3'd0) ? char_code : first_q;
		match_nx[0] = prev_m[0] && (count_q < 3'd3) && (char_code == int_char(count_q));
		match_nx[1] = prev_m[1] && (count_q < 3'd5) && (char_code == float_char(count_q));
		count_nx = (count_q < CountMax) ? count_q + 3'd1 : count_q;
		scan_nx = next_state((count_q == 3'd0) ? ST_START : scan_q, char_code);
	end

	always_comb begin
		q_rec.cls = CLS_ERROR;
		q_rec.code = CodeNone;
		q_rec.ctr = CTR_NONE;
		unique case (scan_nx)
			ST_IDENT: begin
				if (match_nx[0] && count_nx == 3'd3) begin
					q_rec.cls = CLS_RESERVED;
					q_rec.code = CodeInt;
				end else if (match_nx[1] && count_nx == 3'd5) begin
					q_rec.cls = CLS_RESERVED;
					q_rec.code = CodeFloat;
				end else begin
					q_rec.cls = CLS_ID;
					q_rec.ctr = CTR_ID;
				end
			end
			ST_REL1: begin
				if (first_nx == "!") begin
					q_rec.cls = CLS_LOGIC;
				end else if (first_nx == "=") begin
					q_rec.cls = CLS_ASSIGN;
					q_rec.code = CodeAssign;
				end else begin
					q_rec.cls = CLS_RELOP;
					q_rec.code = (first_nx == ">") ? CodeGt : CodeLt;
				end
			end
			ST_REL2: begin
				q_rec.cls = CLS_RELOP;
				if (first_nx == ">") q_rec.code = CodeGe;
				else if (first_nx == "<") q_rec.code = CodeLe;
				else if (first_nx == "!") q_rec.code = CodeNe;
				else q_rec.code = CodeEq;
			end
			ST_MUL: begin
				q_rec.cls = CLS_ARITH;
				q_rec.code = (first_nx == "*") ? CodeMul : CodeDiv;
			end
			ST_SIGN: begin
				q_rec.cls = CLS_ARITH;
				q_rec.code = (first_nx == "+") ? CodeAdd : CodeSub;
			end
			ST_AMP2: begin
				q_rec.cls = CLS_LOGIC;
				q_rec.code = CodeAnd;
			end
			ST_BAR2: begin
				q_rec.cls = CLS_LOGIC;
				q_rec.code = CodeOr;
			end
			ST_INT: begin
				q_rec.cls = CLS_INT;
				q_rec.ctr = CTR_INT;
			end
			ST_DEC: begin
				q_rec.cls = CLS_DEC;
				q_rec.ctr = CTR_DEC;
			end
			ST_EXP: begin
				q_rec.cls = CLS_EXP;
				q_rec.ctr = CTR_EXP;
			end
			ST_SEP: begin
				q_rec.cls = CLS_SEP;
				q_rec.code = (first_nx == ",") ? CodeComma : CodeSemi;
			end
			default: begin
				q_rec.cls = CLS_ERROR;
			end
		endcase
	end

	assign q_valid = take && is_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_q <= ST_START;
			first_q <= 8'd0;
			count_q <= 3'd0;
			match_q <= 2'b00;
		end else if (take) begin
			first_q <= first_nx;
			if (is_last) begin
				scan_q <= ST_START;
				count_q <= 3'd0;
				match_q <= 2'b00;
			end else begin
				scan_q <= scan_nx;
				count_q <= count_nx;
				match_q <= match_nx;
			end
		end
	end

endmodule

// ===== rtl/core/tci_queue.sv =====
// Two-entry queue of token records between the front end and the back end.
// Depends on tci_pkg for the record type.
module tci_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push_valid,
	output logic                push_ready,
	input  tci_pkg::tci_rec_t   push_rec,
	output logic                pop_valid,
	input  logic                pop_ready,
	output tci_pkg::tci_rec_t   pop_rec
);
	import tci_pkg::*;

	tci_rec_t mem_q [2];
	logic wr_ptr_q;
	logic rd_ptr_q;
	logic [1:0] count_q;
	logic push;
	logic pop;

	assign push_ready = (count_q != 2'd2);
	assign pop_valid = (count_q != 2'd0);
	assign pop_rec = mem_q[rd_ptr_q];
	assign push = push_valid && push_ready;
	assign pop = pop_valid && pop_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_rec;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= ~wr_ptr_q;
			if (pop) rd_ptr_q <= ~rd_ptr_q;
			if (push && !pop) count_q <= count_q + 2'd1;
			else if (pop && !push) count_q <= count_q - 2'd1;
		end
	end

`ifndef SYNTHESIS
	assert property (@(posedge clk) disable iff (!arst_n) count_q != 2'd3)
		else $error("Queue occupancy exceeds its depth.");
	assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == 2'd0 || count_q == 2'd2) |-> (wr_ptr_q == rd_ptr_q))
		else $error("Queue pointers disagree with occupancy.");
	assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> (count_q == $past(count_q) + 2'd1))
		else $error("Queue lost a transfer.");
`endif

endmodule

// ===== rtl/core/tci_back.sv =====
// Back end: holds the base registers and running counters, assigns indices and
// drives the output register. Depends on tci_pkg.
module tci_back (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [tci_pkg::CfgIdxBits-1:0]     cfg_index,
	input  logic [tci_pkg::CfgBits-1:0]        cfg_wdata,
	input  logic                               q_valid,
	output logic                               q_ready,
	input  tci_pkg::tci_rec_t                  q_rec,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic [3:0]                         token_class,
	output logic [tci_pkg::IndexBits-1:0]      index_code
);
	import tci_pkg::*;

	logic [CfgBits-1:0] id_base_q, int_base_q, dec_base_q, exp_base_q;
	logic [IndexBits-1:0] id_off_q, int_off_q, dec_off_q, exp_off_q;
	logic out_valid_q;
	token_class_t cls_q;
	logic [IndexBits-1:0] idx_q;

	logic pop;
	logic [CfgBits-1:0] base_sel;
	logic [IndexBits-1:0] off_sel;
	logic [IndexBits:0] sum;
	logic [IndexBits-1:0] idx_nx;
	logic bump;

	assign q_ready = !out_valid_q || out_ready;
	assign pop = q_valid && q_ready;
	assign out_valid = out_valid_q;
	assign token_class = cls_q;
	assign index_code = idx_q;

	always_comb begin
		base_sel = id_base_q;
		off_sel = id_off_q;
		unique case (q_rec.ctr)
			CTR_INT: begin
				base_sel = int_base_q;
				off_sel = int_off_q;
			end
			CTR_DEC: begin
				base_sel = dec_base_q;
				off_sel = dec_off_q;
			end
			CTR_EXP: begin
				base_sel = exp_base_q;
				off_sel = exp_off_q;
			end
			default: begin
				base_sel = id_base_q;
				off_sel = id_off_q;
			end
		endcase
		sum = (IndexBits+1)'(base_sel) + {1'b0, off_sel};
		if (q_rec.ctr == CTR_NONE) idx_nx = q_rec.code;
		else if (sum > {1'b0, IndexMax}) idx_nx = IndexMax;
		else idx_nx = sum[IndexBits-1:0];
		bump = pop && (off_sel != IndexMax);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			id_base_q <= IdBaseReset;
			int_base_q <= IntBaseReset;
			dec_base_q <= DecBaseReset;
			exp_base_q <= ExpBaseReset;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CfgIdBase: id_base_q <= cfg_wdata;
				CfgIntBase: int_base_q <= cfg_wdata;
				CfgDecBase: dec_base_q <= cfg_wdata;
				default: exp_base_q <= cfg_wdata;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			id_off_q <= '0;
			int_off_q <= '0;
			dec_off_q <= '0;
			exp_off_q <= '0;
		end else if (bump) begin
			unique case (q_rec.ctr)
				CTR_ID: id_off_q <= id_off_q + IndexBits'(1);
				CTR_INT: int_off_q <= int_off_q + IndexBits'(1);
				CTR_DEC: dec_off_q <= dec_off_q + IndexBits'(1);
				CTR_EXP: exp_off_q <= exp_off_q + IndexBits'(1);
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (q_ready) begin
			out_valid_q <= q_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cls_q <= q_rec.cls;
			idx_q <= idx_nx;
		end
	end

`ifndef SYNTHESIS
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && token_class == CLS_ERROR) |-> (index_code == CodeNone))
		else $error("Error token carries a nonzero index.");
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && token_class == CLS_RESERVED) |->
		(index_code == CodeInt || index_code == CodeFloat))
		else $error("Reserved word carries a wrong code.");
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(index_code)))
		else $error("Stalled result changed.");
	assert property (@(posedge clk) disable iff (!arst_n)
		(pop && q_rec.ctr == CTR_NONE) |=> $stable(id_off_q))
		else $error("Identifier counter moved on a fixed-code token.");
`endif

endmodule

// ===== rtl/core/token_classifier_indexer.sv =====
// Token classifier and indexer. Characters of a whitespace-free token arrive one per
// transfer, with is_last on the final one; that transfer yields one result with the token
// class and its index code. A character is taken every cycle while the two-entry record
// queue has room; the token's record passes through the queue and then the output register.
// Identifiers and numbers draw indices from counters that start at the base registers.
// Base registers should be written only while no token is in flight.
module token_classifier_indexer (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [tci_pkg::CfgIdxBits-1:0]     cfg_index,
	input  logic [tci_pkg::CfgBits-1:0]        cfg_wdata,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic [7:0]                         char_code,
	input  logic                               is_last,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic [3:0]                         token_class,
	output logic [tci_pkg::IndexBits-1:0]      index_code
);
	import tci_pkg::*;

	logic f_valid, f_ready;
	tci_rec_t f_rec;
	logic b_valid, b_ready;
	tci_rec_t b_rec;

	tci_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.char_code (char_code),
		.is_last   (is_last),
		.q_ready   (f_ready),
		.q_valid   (f_valid),
		.q_rec     (f_rec)
	);

	tci_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (f_valid),
		.push_ready (f_ready),
		.push_rec   (f_rec),
		.pop_valid  (b_valid),
		.pop_ready  (b_ready),
		.pop_rec    (b_rec)
	);

	tci_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_wdata   (cfg_wdata),
		.q_valid     (b_valid),
		.q_ready     (b_ready),
		.q_rec       (b_rec),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.token_class (token_class),
		.index_code  (index_code)
	);

endmodule
